/* rtl/staq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample to attenuation quantizer package
// Level tables and the nearest-level search of the quantizer, and register map
// codes shared by the quantizer, its checker and the testbench.
// ----------------------------------------------------------------------------
package staq_pkg;

    localparam int unsigned NUM_LEVELS = 16;
    localparam int unsigned IDX_W      = $clog2(NUM_LEVELS);
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;

    typedef logic [SAMPLE_W-1:0] level_t;
    typedef logic [IDX_W-1:0]    level_idx_t;
    typedef logic [BYTE_W-1:0]   out_byte_t;

    localparam logic REG_USE_REAL_TABLE = 1'b0;
    localparam logic REG_PACK_MODE      = 1'b1;

    localparam out_byte_t CMD_PREFIX = 8'h90;

    localparam level_t TUNED_LEVELS [NUM_LEVELS] = '{
        8'd255, 8'd191, 8'd159, 8'd143, 8'd135, 8'd131, 8'd129, 8'd128,
        8'd127, 8'd125, 8'd121, 8'd113, 8'd97,  8'd65,  8'd30,  8'd0
    };

    localparam level_t REAL_LEVELS [NUM_LEVELS] = '{
        8'd254, 8'd202, 8'd160, 8'd128, 8'd100, 8'd80, 8'd64, 8'd50,
        8'd40,  8'd32,  8'd24,  8'd20,  8'd16,  8'd12, 8'd10, 8'd0
    };

    // Distances are compared in a four-level tree. The left operand always
    // covers the lower indices, so it wins on a tie.
    function automatic level_idx_t nearest_index(input level_t smp, input logic use_real);
        level_t     lvl;
        level_t     d1 [16];
        level_idx_t i1 [16];
        level_t     d2 [8];
        level_idx_t i2 [8];
        level_t     d3 [4];
        level_idx_t i3 [4];
        level_t     d4 [2];
        level_idx_t i4 [2];
        for (int k = 0; k < 16; k++)
        begin
            lvl   = use_real ? REAL_LEVELS[k] : TUNED_LEVELS[k];
            d1[k] = (lvl > smp) ? level_t'(lvl - smp) : level_t'(smp - lvl);
            i1[k] = level_idx_t'(k);
        end
        for (int k = 0; k < 8; k++)
        begin
            if (d1[2*k+1] < d1[2*k])
            begin
                d2[k] = d1[2*k+1];
                i2[k] = i1[2*k+1];
            end
            else
            begin
                d2[k] = d1[2*k];
                i2[k] = i1[2*k];
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            if (d2[2*k+1] < d2[2*k])
            begin
                d3[k] = d2[2*k+1];
                i3[k] = i2[2*k+1];
            end
            else
            begin
                d3[k] = d2[2*k];
                i3[k] = i2[2*k];
            end
        end
        for (int k = 0; k < 2; k++)
        begin
            if (d3[2*k+1] < d3[2*k])
            begin
                d4[k] = d3[2*k+1];
                i4[k] = i3[2*k+1];
            end
            else
            begin
                d4[k] = d3[2*k];
                i4[k] = i3[2*k];
            end
        end
        return (d4[1] < d4[0]) ? i4[1] : i4[0];
    endfunction

endpackage
`default_nettype wire

/* rtl/sample_to_attenuation_quantizer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// A result request is formed from the input register and held in the result register.
// Throughput: one sample per cycle while the result register is not stalled; the input register and the result register
// let a new sample enter while a finished result waits to be taken.
// In pack mode a request leaves for each pair of samples; a lone last sample is dropped.
// Reset: rst_n clears both configuration registers, the pair state and the valid flags.
// ----------------------------------------------------------------------------
// Sample to attenuation quantizer
// Maps each 8-bit sample to the nearest of 16 levels and emits command bytes
// or packed index pairs.
// ----------------------------------------------------------------------------
module sample_to_attenuation_quantizer_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [staq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [staq_pkg::PDATA_W-1:0]  pwdata,
    output logic      [staq_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [staq_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [7:0] sample
    input  wire logic                          s_axis_tlast,   // last_sample
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [staq_pkg::BYTE_W-1:0]   m_axis_tdata    // [7:0] out_byte
);
    import staq_pkg::*;

    logic       use_real_reg;
    logic       use_real_next;
    logic       pack_mode_reg;
    logic       pack_mode_next;
    logic       in_valid_reg;
    logic       in_valid_next;
    level_t     sample_reg;
    logic       last_reg;
    logic       half_full_reg;
    logic       half_full_next;
    level_idx_t held_reg;
    level_idx_t held_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_byte_t  out_byte_reg;
    out_byte_t  out_byte_next;

    logic       cfg_write;
    logic       in_take;
    logic       produce;
    logic       advance;
    level_idx_t idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        use_real_next  = use_real_reg;
        pack_mode_next = pack_mode_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_USE_REAL_TABLE: use_real_next  = pwdata[0];
                REG_PACK_MODE:      pack_mode_next = pwdata[0];
                default:            use_real_next  = use_real_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_USE_REAL_TABLE: prdata[0] = use_real_reg;
            REG_PACK_MODE:      prdata[0] = pack_mode_reg;
            default:            prdata[0] = 1'b0;
        endcase
    end

    assign idx           = nearest_index(sample_reg, use_real_reg);
    assign produce       = !pack_mode_reg || half_full_reg;
    assign advance       = in_valid_reg && (!produce || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = in_take || (in_valid_reg && !advance);

    always_comb
    begin
        half_full_next = half_full_reg;
        held_next      = held_reg;
        if (advance)
        begin
            if (pack_mode_reg)
            begin
                if (half_full_reg)
                begin
                    half_full_next = 1'b0;
                    held_next      = '0;
                end
                else if (!last_reg)
                begin
                    half_full_next = 1'b1;
                    held_next      = idx;
                end
            end
            if (last_reg)
            begin
                half_full_next = 1'b0;
                held_next      = '0;
            end
        end
    end

    always_comb
    begin
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (advance && produce)
        begin
            out_valid_next = 1'b1;
            if (pack_mode_reg)
            begin
                out_byte_next = {held_reg, idx};
            end
            else
            begin
                out_byte_next = CMD_PREFIX | out_byte_t'(idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_real_reg  <= 1'b0;
            pack_mode_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            half_full_reg <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            use_real_reg  <= use_real_next;
            pack_mode_reg <= pack_mode_next;
            in_valid_reg  <= in_valid_next;
            half_full_reg <= half_full_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= s_axis_tdata;
            last_reg   <= s_axis_tlast;
        end
        out_byte_reg <= out_byte_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;

endmodule
`default_nettype wire

/* rtl/staq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample to attenuation quantizer checker
// Port-level properties of the quantizer, bound to the quantizer module.
// ----------------------------------------------------------------------------
module staq_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [staq_pkg::PADDR_W-1:0]  paddr,
    input wire logic [staq_pkg::PDATA_W-1:0]  pwdata,
    input wire logic [staq_pkg::PDATA_W-1:0]  prdata,
    input wire logic                          pready,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [staq_pkg::BYTE_W-1:0]   m_axis_tdata
);
    import staq_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result request changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input stalled while the result register is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("Result request without a matching sample.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[2] == REG_PACK_MODE)
        ##1 (paddr[2] == REG_PACK_MODE) |-> prdata[0] == $past(pwdata[0]))
        else $error("Register read does not return the written value.");

endmodule

bind sample_to_attenuation_quantizer_unit staq_checker u_staq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample to attenuation quantizer testbench
// Drives samples over the stream input and writes the table and mode
// registers over APB between phases. A scoreboard predicts every output
// byte, either a command byte or a packed index pair, and checks the stream
// output against it in order. Random gaps on the input and stall patterns on
// the output exercise the handshakes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD     = 12;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 12;

    localparam int RDY_ALWAYS = 0;
    localparam int RDY_RANDOM = 1;
    localparam int RDY_RUNS   = 2;

    localparam logic [7:0] CMD_PREFIX_BYTE = 8'h90;

    localparam logic [7:0] TUNED_TAB [16] = '{
        8'd255, 8'd191, 8'd159, 8'd143, 8'd135, 8'd131, 8'd129, 8'd128,
        8'd127, 8'd125, 8'd121, 8'd113, 8'd97,  8'd65,  8'd30,  8'd0
    };
    localparam logic [7:0] REAL_TAB [16] = '{
        8'd254, 8'd202, 8'd160, 8'd128, 8'd100, 8'd80, 8'd64, 8'd50,
        8'd40,  8'd32,  8'd24,  8'd20,  8'd16,  8'd12, 8'd10, 8'd0
    };

    class attenuation_scoreboard;
        logic       use_real;
        logic       pack_mode;
        logic       half_full;
        logic [3:0] held_nibble;
        logic [7:0] pending_bytes [$];
        int         errors;
        int         bytes_checked;

        function new();
            use_real      = 1'b0;
            pack_mode     = 1'b0;
            half_full     = 1'b0;
            held_nibble   = 4'h0;
            errors        = 0;
            bytes_checked = 0;
        endfunction

        function void write_register(logic idx, logic val);
            if (idx == staq_pkg::REG_USE_REAL_TABLE)
                use_real = val;
            else
                pack_mode = val;
        endfunction

        function logic [3:0] nearest_level_index(logic [7:0] smp);
            int best;
            int best_dist;
            int lvl_dist;
            int lvl;
            int s;
            best      = 0;
            best_dist = 512;
            s         = int'(smp);
            for (int k = 0; k < 16; k++)
            begin
                lvl      = use_real ? int'(REAL_TAB[k]) : int'(TUNED_TAB[k]);
                lvl_dist = (lvl > s) ? lvl - s : s - lvl;
                if (lvl_dist < best_dist)
                begin
                    best_dist = lvl_dist;
                    best      = k;
                end
            end
            return 4'(best);
        endfunction

        function void note_sample(logic [7:0] smp, logic lst);
            logic [3:0] idx;
            idx = nearest_level_index(smp);
            if (pack_mode)
            begin
                if (half_full)
                begin
                    pending_bytes.push_back({held_nibble, idx});
                    half_full   = 1'b0;
                    held_nibble = 4'h0;
                end
                else if (!lst)
                begin
                    half_full   = 1'b1;
                    held_nibble = idx;
                end
            end
            else
            begin
                pending_bytes.push_back(CMD_PREFIX_BYTE | {4'h0, idx});
            end
            if (lst)
            begin
                half_full   = 1'b0;
                held_nibble = 4'h0;
            end
        endfunction

        function void check_byte(logic [7:0] actual);
            logic [7:0] want;
            if (pending_bytes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: output byte %02h arrived with nothing pending", actual);
            end
            else
            begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (actual !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: out_byte expected %02h, got %02h", want, actual);
                end
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        function void check_leftover();
            if (pending_bytes.size() > 0)
            begin
                errors += pending_bytes.size();
                $display("ERROR: %0d expected bytes never arrived", pending_bytes.size());
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [staq_pkg::PADDR_W-1:0]   paddr;
    logic [staq_pkg::PDATA_W-1:0]   pwdata;
    logic [staq_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [staq_pkg::SAMPLE_W-1:0]  s_axis_tdata;   // [7:0] sample
    logic                           s_axis_tlast;   // last_sample
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [staq_pkg::BYTE_W-1:0]    m_axis_tdata;   // [7:0] out_byte

    attenuation_scoreboard sb = new();

    int   rdy_mode;
    int   stall_run;
    logic stall_hold;
    int   idle_cycles;
    bit   gaps_on;
    int   burst_left;
    int   samples_sent;
    int   settings_used;

    sample_to_attenuation_quantizer_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        case (rdy_mode)
            RDY_ALWAYS:
                m_axis_tready <= 1'b1;
            RDY_RANDOM:
                m_axis_tready <= ($urandom_range(0, 9) < 6);
            default:
            begin
                if (stall_run == 0)
                begin
                    stall_hold = ~stall_hold;
                    stall_run  = $urandom_range(1, 12);
                end
                stall_run = stall_run - 1;
                m_axis_tready <= ~stall_hold;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_byte(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                 || (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_sample(input logic [7:0] smp, input logic lst);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_sample(smp, lst);
        samples_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic write_reg(input logic idx, input logic val);
        logic [31:0] data;
        data    = $urandom();
        data[0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_register(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic real_tab, input logic pack);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(staq_pkg::REG_USE_REAL_TABLE, real_tab);
        write_reg(staq_pkg::REG_PACK_MODE, pack);
        settings_used++;
    endtask

    function automatic logic [7:0] pick_sample(logic real_tab);
        int sel;
        int k;
        int a;
        int b;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, 14);
        a   = real_tab ? REAL_TAB[k] : TUNED_TAB[k];
        b   = real_tab ? REAL_TAB[k + 1] : TUNED_TAB[k + 1];
        if (sel < 65)
            return 8'($urandom_range(0, 255));
        else if (sel < 80)
            return 8'((a + b) / 2);
        else if (sel < 90)
            return 8'(a + $urandom_range(0, 2) - 1);
        else
            return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
    endfunction

    initial
    begin
        logic real_tab;
        logic pack;
        int   count;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        rdy_mode      <= RDY_RANDOM;
        stall_run     = 0;
        stall_hold    = 1'b0;
        gaps_on       = 1'b1;
        burst_left    = 0;
        samples_sent  = 0;
        settings_used = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes and exact ties between neighboring levels, hand-tuned table.
        configure(1'b0, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd128, 1'b0);
        send_sample(8'd127, 1'b0);
        send_sample(8'd223, 1'b0);
        send_sample(8'd81, 1'b0);
        send_sample(8'd15, 1'b0);
        send_sample(8'd1, 1'b1);

        configure(1'b1, 1'b0);
        send_sample(8'd228, 1'b0);
        send_sample(8'd57, 1'b0);
        send_sample(8'd254, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd129, 1'b1);

        // Pairs, a dropped trailing odd sample, a last sample that closes a
        // pair, and a nibble left held across a switch to command mode.
        configure(1'b1, 1'b1);
        send_sample(8'd10, 1'b0);
        send_sample(8'd200, 1'b0);
        send_sample(8'd30, 1'b1);
        send_sample(8'd90, 1'b0);
        send_sample(8'd91, 1'b1);
        send_sample(8'd77, 1'b0);

        configure(1'b0, 1'b0);
        send_sample(8'd240, 1'b0);
        send_sample(8'd3, 1'b0);

        configure(1'b0, 1'b1);
        send_sample(8'd150, 1'b0);
        send_sample(8'd255, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < 4)
            begin
                real_tab = ph[0];
                pack     = ph[1];
            end
            else
            begin
                real_tab = 1'($urandom_range(0, 1));
                pack     = 1'($urandom_range(0, 1));
            end
            configure(real_tab, pack);
            gaps_on  = (ph % 4) != 1;
            rdy_mode <= ph % 3;
            count    = $urandom_range(50, 100);
            for (int i = 0; i < count; i++)
                send_sample(pick_sample(real_tab), $urandom_range(0, 11) == 0);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_leftover();
        $display("Sent %0d samples and checked %0d output bytes over %0d register settings,",
                 samples_sent, sb.bytes_checked, settings_used);
        $display("covering both level tables, command and pack modes, ties and end of stream.");
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/staq_pkg.sv
rtl/sample_to_attenuation_quantizer_unit.sv
rtl/staq_checker.sv
dv/testbench.sv
